### design/tts_pkg.sv
// Shared types, constants and bound functions for the two-tier transposition store.
`default_nettype none

package tts_pkg;

   localparam int TTS_INDEX_BITS  = 12;
   localparam int TTS_SCORE_LIMIT = 6400;

   typedef enum logic {
      CMD_FULL = 1'b0,
      CMD_NULL = 1'b1
   } tts_cmd_code_type;

   typedef enum logic [1:0] {
      BANK_SHARED   = 2'd0,
      BANK_BLACK    = 2'd1,
      BANK_WHITE    = 2'd2,
      BANK_RESERVED = 2'd3
   } tts_bank_type;

   typedef enum logic [2:0] {
      ACT_DEEP_REFINED  = 3'd0,
      ACT_NEW_REFINED   = 3'd1,
      ACT_DEEP_REPLACED = 3'd2,
      ACT_NEW_REPLACED  = 3'd3,
      ACT_NO_CHANGE     = 3'd4
   } tts_action_type;

   typedef enum logic {
      REG_AGE_BLACK = 1'b0,
      REG_AGE_WHITE = 1'b1
   } tts_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EVAL  = 3'b100
   } tts_state_type;

   typedef struct packed {
      logic [7:0]         date;
      logic [7:0]         depth;
      logic [7:0]         sel;
      logic [7:0]         move;
      logic signed [15:0] upper;
      logic signed [15:0] lower;
   } tts_rec_type;

   typedef struct packed {
      logic [63:0] deep_key;
      tts_rec_type deep_rec;
      logic [63:0] new_key;
      tts_rec_type new_rec;
   } tts_entry_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic evaluate;
   } tts_ctrl_type;

   typedef struct packed {
      logic clear_last;
   } tts_status_type;

   function automatic tts_rec_type refine_bounds(
      input tts_rec_type        r,
      input logic               cmd,
      input logic signed [15:0] alpha,
      input logic signed [15:0] beta,
      input logic signed [15:0] score,
      input logic signed [15:0] lim
   );
      tts_rec_type o;
      o = r;
      if (cmd == CMD_FULL) begin
         if (score < beta && score < o.upper) o.upper = score;
         if (score > o.lower) o.lower = score;
         if (o.lower > o.upper) begin
            o.upper = (score < beta) ? score : lim;
            o.lower = score;
         end
      end else begin
         if (score > alpha) begin
            if (score > o.lower) o.lower = score;
         end else if (score < o.upper) begin
            o.upper = score;
         end
         if (o.lower > o.upper) begin
            if (score > alpha) begin
               o.upper = lim;
               o.lower = score;
            end else begin
               o.upper = score;
               o.lower = -lim;
            end
         end
      end
      return o;
   endfunction

   function automatic tts_rec_type fresh_bounds(
      input logic               cmd,
      input logic signed [15:0] alpha,
      input logic signed [15:0] beta,
      input logic signed [15:0] score,
      input logic signed [15:0] lim
   );
      tts_rec_type o;
      o = '0;
      if (cmd == CMD_FULL) begin
         o.lower = (score > alpha) ? score : -lim;
         o.upper = (score < beta) ? score : lim;
      end else if (score > alpha) begin
         o.upper = lim;
         o.lower = score;
      end else begin
         o.upper = score;
         o.lower = -lim;
      end
      return o;
   endfunction

endpackage

`default_nettype wire

### design/tts_req_if.sv
// Request channel interface of the transposition store.
`default_nettype none

interface tts_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [63:0]        key;
   logic [1:0]         bank;
   logic               pv_bonus;
   logic [7:0]         selectivity_level;
   logic [7:0]         search_depth;
   logic signed [15:0] window_low;
   logic signed [15:0] window_high;
   logic signed [15:0] score;
   logic [7:0]         best_move;

   modport source (
      output valid, cmd, key, bank, pv_bonus, selectivity_level, search_depth,
             window_low, window_high, score, best_move,
      input  ready
   );

   modport sink (
      input  valid, cmd, key, bank, pv_bonus, selectivity_level, search_depth,
             window_low, window_high, score, best_move,
      output ready
   );
endinterface

`default_nettype wire

### design/tts_rsp_if.sv
// Response channel interface of the transposition store.
`default_nettype none

interface tts_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic       demoted;

   modport source (
      output valid, action, demoted,
      input  ready
   );

   modport sink (
      input  valid, action, demoted,
      output ready
   );
endinterface

`default_nettype wire

### design/tts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tts_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/tts_csr.sv
// Date stamp registers behind the APB-style configuration port.
`default_nettype none

module tts_csr import tts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [7:0]       age_black,
   output logic [7:0]       age_white
);

   logic [7:0] age_black_ff;
   logic [7:0] age_white_ff;
   logic       wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_black_ff <= '0;
         age_white_ff <= '0;
      end else if (wr_hit) begin
         if (paddr[2] == REG_AGE_WHITE) begin
            age_white_ff <= pwdata[7:0];
         end else begin
            age_black_ff <= pwdata[7:0];
         end
      end
   end

   assign prdata    = {24'd0, (paddr[2] == REG_AGE_WHITE) ? age_white_ff : age_black_ff};
   assign age_black = age_black_ff;
   assign age_white = age_white_ff;

endmodule

`default_nettype wire

### design/tts_ctrl.sv
// Controller state machine: clearing pass, request capture, evaluation, response hold.
`default_nettype none

module tts_ctrl import tts_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire tts_status_type  dp_status,
   output tts_ctrl_type         ctrl_cmd
);

   tts_state_type state_ff;
   tts_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          room;

   assign room = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      ctrl_cmd          = '0;
      req_ready         = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ctrl_cmd.clear = 1'b1;
            if (dp_status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = room;
            if (req_valid && room) begin
               ctrl_cmd.capture = 1'b1;
               state_in         = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ctrl_cmd.evaluate = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (ctrl_cmd.evaluate) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_eval_after_capture: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.capture |=> ctrl_cmd.evaluate)
      else $error("evaluation did not follow a captured request");

   a_response_after_eval: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.evaluate |=> rsp_valid_ff)
      else $error("evaluation did not produce a response");

   a_no_capture_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.clear |-> !req_ready && !ctrl_cmd.capture && !ctrl_cmd.evaluate)
      else $error("request taken during the clearing pass");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.evaluate |-> !rsp_valid_ff)
      else $error("evaluation would overwrite a pending response");

endmodule

`default_nettype wire

### design/tts_dpath.sv
// Datapath: request registers, entry RAM, replacement decision and response registers.
`default_nettype none

module tts_dpath import tts_pkg::*; #(
   parameter int INDEX_BITS  = TTS_INDEX_BITS,
   parameter int SCORE_LIMIT = TTS_SCORE_LIMIT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tts_ctrl_type       ctrl_cmd,
   output tts_status_type          dp_status,
   input  wire logic [7:0]         age_black,
   input  wire logic [7:0]         age_white,
   input  wire logic               req_cmd,
   input  wire logic [63:0]        req_key,
   input  wire logic [1:0]         req_bank,
   input  wire logic               req_pv_bonus,
   input  wire logic [7:0]         req_selectivity_level,
   input  wire logic [7:0]         req_search_depth,
   input  wire logic signed [15:0] req_window_low,
   input  wire logic signed [15:0] req_window_high,
   input  wire logic signed [15:0] req_score,
   input  wire logic [7:0]         req_best_move,
   output logic [2:0]              rsp_action,
   output logic                    rsp_demoted
);

   localparam int                 DEPTH   = 2 ** INDEX_BITS;
   localparam int                 ENTRY_W = $bits(tts_entry_type);
   localparam logic signed [15:0] LIM     = 16'(SCORE_LIMIT);

   logic [INDEX_BITS-1:0] clr_cnt_ff;
   logic [INDEX_BITS-1:0] clr_cnt_in;

   logic                  cmd_ff;
   logic [63:0]           key_ff;
   logic                  bad_ff;
   logic [7:0]            sel_ff;
   logic [7:0]            depth_ff;
   logic signed [15:0]    alpha_ff;
   logic signed [15:0]    beta_ff;
   logic signed [15:0]    score_ff;
   logic [7:0]            move_ff;
   logic [8:0]            date_ff;
   logic [INDEX_BITS-1:0] idx_ff;

   logic [INDEX_BITS-1:0] idx_in;
   logic [8:0]            date_in;
   logic [31:0]           key_hi;

   tts_action_type        action_ff;
   tts_action_type        action_in;
   logic                  demoted_ff;
   logic                  demoted_in;

   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic [INDEX_BITS-1:0] ram_wr_addr;
   logic                  ram_wr_en;

   tts_entry_type         rd;
   tts_entry_type         wr;
   tts_rec_type           d;
   tts_rec_type           n;
   tts_rec_type           fr;
   tts_rec_type           rr;
   logic                  window_ok;
   logic                  d_hit;
   logic                  n_hit;
   logic                  d_prio;
   logic                  demote;
   logic [8:0]            d_date9;

   // Entry index and date stamp, formed while the request is taken.
   assign key_hi = req_key[63:32];

   always_comb begin
      case (req_bank)
         BANK_SHARED: idx_in = key_hi[INDEX_BITS-1:0];
         BANK_BLACK:  idx_in = {1'b0, key_hi[INDEX_BITS-2:0]};
         default:     idx_in = {1'b1, key_hi[INDEX_BITS-2:0]};
      endcase
      date_in = {1'b0, (req_bank == BANK_WHITE) ? age_white : age_black}
              + 9'((req_cmd == CMD_FULL) && req_pv_bonus);
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key;
         bad_ff   <= (req_bank == BANK_RESERVED);
         sel_ff   <= req_selectivity_level;
         depth_ff <= req_search_depth;
         alpha_ff <= req_window_low;
         beta_ff  <= req_window_high;
         score_ff <= req_score;
         move_ff  <= req_best_move;
         date_ff  <= date_in;
         idx_ff   <= idx_in;
      end
      if (ctrl_cmd.evaluate) begin
         action_ff  <= action_in;
         demoted_ff <= demoted_in;
      end
   end

   assign clr_cnt_in = clr_cnt_ff + INDEX_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctrl_cmd.clear) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign dp_status.clear_last = &clr_cnt_ff;

   // Replacement decision on the entry read back from the RAM.
   always_comb begin
      rd        = tts_entry_type'(ram_rd_data);
      d         = rd.deep_rec;
      n         = rd.new_rec;
      d_date9   = {1'b0, d.date};
      window_ok = (cmd_ff == CMD_NULL) || (alpha_ff < score_ff);
      d_hit     = (key_ff == rd.deep_key) && (sel_ff == d.sel) && (depth_ff == d.depth)
                && window_ok;
      n_hit     = (key_ff == rd.new_key) && (sel_ff == n.sel) && (depth_ff == n.depth)
                && window_ok;
      d_prio    = (rd.deep_key == key_ff) || (d_date9 < date_ff)
                || ((d_date9 == date_ff) && ((d.depth < depth_ff)
                || ((d.depth == depth_ff) && (d.sel < sel_ff))));
      demote    = (rd.deep_key != key_ff) && ((rd.new_key == key_ff) || (n.date < d.date)
                || ((n.date == d.date) && ((n.depth < d.depth)
                || ((n.depth == d.depth) && (n.sel <= d.sel)))));

      fr       = fresh_bounds(cmd_ff, alpha_ff, beta_ff, score_ff, LIM);
      fr.date  = date_ff[7:0];
      fr.depth = depth_ff;
      fr.sel   = sel_ff;
      fr.move  = move_ff;

      rr      = refine_bounds(d_hit ? d : n, cmd_ff, alpha_ff, beta_ff, score_ff, LIM);
      rr.date = date_ff[7:0];
      rr.move = move_ff;

      wr         = rd;
      demoted_in = 1'b0;
      if (bad_ff) begin
         action_in = ACT_NO_CHANGE;
      end else if (d_hit) begin
         action_in   = ACT_DEEP_REFINED;
         wr.deep_key = key_ff;
         wr.deep_rec = rr;
      end else if (n_hit) begin
         action_in  = ACT_NEW_REFINED;
         wr.new_key = key_ff;
         wr.new_rec = rr;
      end else if (d_prio) begin
         action_in = ACT_DEEP_REPLACED;
         if (demote) begin
            wr.new_key = rd.deep_key;
            wr.new_rec = d;
            demoted_in = 1'b1;
         end
         wr.deep_key = key_ff;
         wr.deep_rec = fr;
      end else begin
         action_in  = ACT_NEW_REPLACED;
         wr.new_key = key_ff;
         wr.new_rec = fr;
      end
   end

   assign ram_wr_en   = ctrl_cmd.clear || (ctrl_cmd.evaluate && !bad_ff);
   assign ram_wr_addr = ctrl_cmd.clear ? clr_cnt_ff : idx_ff;
   assign ram_wr_data = ctrl_cmd.clear ? '0 : ENTRY_W'(wr);

   tts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   assign rsp_action  = action_ff;
   assign rsp_demoted = demoted_ff;

endmodule

`default_nettype wire

### design/two_tier_transposition_store.sv
// Top level of the two-tier transposition store.
//
// Requests arrive on req_bus; each one returns one response on rsp_bus with
// the action taken and whether the old deepest record was demoted, and each
// one outside the reserved bank updates a single entry, which holds a deepest
// record and a newest record. Two date stamps are written through the
// APB-style port; pready is always high and a write lands at the access cycle.
// A request is accepted at an edge with valid and ready high, the entry is
// read from the RAM in the next cycle and written back in the same cycle
// the response is loaded, so the response is valid from the edge after the
// one at which the request was accepted. Ready stays low while a request is
// evaluated, so the RAM read-modify-write of one entry ends before the next
// request is accepted.
//
// After reset the block sweeps all 2**INDEX_BITS RAM entries (4096 by
// default) to zero, one entry per cycle, with ready held low; configuration
// writes are taken during that pass. A response that is not taken stays in
// its output register, and the next request is accepted in the cycle in
// which that response is taken.
`default_nettype none

module two_tier_transposition_store import tts_pkg::*; #(
   parameter int INDEX_BITS  = TTS_INDEX_BITS,
   parameter int SCORE_LIMIT = TTS_SCORE_LIMIT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tts_req_if.sink          req_bus,
   tts_rsp_if.source        rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0]     age_black_w;
   logic [7:0]     age_white_w;
   tts_ctrl_type   ctrl_cmd;
   tts_status_type dp_status;

   tts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .age_black (age_black_w),
      .age_white (age_white_w)
   );

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   tts_dpath #(
      .INDEX_BITS  (INDEX_BITS),
      .SCORE_LIMIT (SCORE_LIMIT)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl_cmd              (ctrl_cmd),
      .dp_status             (dp_status),
      .age_black             (age_black_w),
      .age_white             (age_white_w),
      .req_cmd               (req_bus.cmd),
      .req_key               (req_bus.key),
      .req_bank              (req_bus.bank),
      .req_pv_bonus          (req_bus.pv_bonus),
      .req_selectivity_level (req_bus.selectivity_level),
      .req_search_depth      (req_bus.search_depth),
      .req_window_low        (req_bus.window_low),
      .req_window_high       (req_bus.window_high),
      .req_score             (req_bus.score),
      .req_best_move         (req_bus.best_move),
      .rsp_action            (rsp_bus.action),
      .rsp_demoted           (rsp_bus.demoted)
   );

endmodule

`default_nettype wire

### tb/two_tier_transposition_store_tb.sv
// Self-checking testbench for the two-tier transposition store, with a model of the store.
`default_nettype none

module two_tier_transposition_store_tb import tts_pkg::*; ();

   localparam int         ENTRIES          = 1 << TTS_INDEX_BITS;
   localparam int         KEY_POOL_SIZE    = 12;
   localparam int         RUN_LIMIT_CYCLES = 600000;
   localparam int         MAX_REPORTS      = 10;
   localparam logic [1:0] BANK_BAD         = BANK_RESERVED;

   typedef struct {
      logic               cmd;
      logic [63:0]        key;
      logic [1:0]         bank;
      logic               pv;
      logic [7:0]         sel;
      logic [7:0]         depth;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic signed [15:0] score;
      logic [7:0]         move;
   } store_update_type;

   typedef struct {
      tts_action_type action;
      logic           demoted;
   } update_outcome_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tts_req_if req_bus ();
   tts_rsp_if rsp_bus ();

   two_tier_transposition_store u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [63:0] deep_key_mem [ENTRIES];
   tts_rec_type deep_rec_mem [ENTRIES];
   logic [63:0] new_key_mem  [ENTRIES];
   tts_rec_type new_rec_mem  [ENTRIES];
   logic [7:0]  age_black;
   logic [7:0]  age_white;

   logic [63:0] key_pool   [KEY_POOL_SIZE];
   logic [1:0]  pool_bank  [KEY_POOL_SIZE];
   logic [7:0]  pool_depth [KEY_POOL_SIZE];
   logic [7:0]  pool_sel   [KEY_POOL_SIZE];
   logic [11:0] shared_spots [3] = '{12'h005, 12'h805, 12'h7FF};

   update_outcome_type pending_outcomes [$];
   int                 req_idle_pct  = 16;
   int                 rsp_stall_pct = 55;
   int                 requests_sent;
   int                 responses_seen;
   int                 mismatches;
   int                 demotions;
   int                 action_tally [5];

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : response_check
      update_outcome_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         responses_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: response %0d with no request pending: action %0d demoted %0b",
                        $time, responses_seen, rsp_bus.action, rsp_bus.demoted);
            end
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.action !== want.action || rsp_bus.demoted !== want.demoted) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display({"%0t: response %0d: action %0d demoted %0b, ",
                            "wanted action %0d demoted %0b"},
                           $time, responses_seen, rsp_bus.action, rsp_bus.demoted,
                           want.action, want.demoted);
               end
            end
         end
      end
   end

   function automatic bit record_matches(logic [63:0] k, tts_rec_type r,
                                         store_update_type u);
      return k == u.key && r.sel == u.sel && r.depth == u.depth &&
             (u.cmd == CMD_NULL || u.alpha < u.score);
   endfunction

   function automatic tts_rec_type tighten_bounds(tts_rec_type r, store_update_type u);
      int lo, up, a, b, s;
      lo = $signed(r.lower);
      up = $signed(r.upper);
      a  = u.alpha;
      b  = u.beta;
      s  = u.score;
      if (u.cmd == CMD_FULL) begin
         if (s < b && s < up) up = s;
         if (s > lo) lo = s;
         if (lo > up) begin
            up = (s < b) ? s : TTS_SCORE_LIMIT;
            lo = s;
         end
      end else begin
         if (s > a) begin
            if (s > lo) lo = s;
         end else if (s < up) begin
            up = s;
         end
         if (lo > up) begin
            if (s > a) begin
               up = TTS_SCORE_LIMIT;
               lo = s;
            end else begin
               up = s;
               lo = -TTS_SCORE_LIMIT;
            end
         end
      end
      r.lower = 16'(lo);
      r.upper = 16'(up);
      return r;
   endfunction

   function automatic tts_rec_type with_fresh_bounds(tts_rec_type r, store_update_type u);
      int lo, up, a, b, s;
      a = u.alpha;
      b = u.beta;
      s = u.score;
      if (u.cmd == CMD_FULL) begin
         lo = (s > a) ? s : -TTS_SCORE_LIMIT;
         up = (s < b) ? s : TTS_SCORE_LIMIT;
      end else if (s > a) begin
         lo = s;
         up = TTS_SCORE_LIMIT;
      end else begin
         lo = -TTS_SCORE_LIMIT;
         up = s;
      end
      r.lower = 16'(lo);
      r.upper = 16'(up);
      return r;
   endfunction

   function automatic update_outcome_type predict_update(store_update_type u);
      update_outcome_type res;
      logic [31:0]        hi;
      int                 half, idx, date;
      bit                 deep_first, demote;
      tts_rec_type        d, n;
      logic [63:0]        dk, nk;
      res.action  = ACT_NO_CHANGE;
      res.demoted = 1'b0;
      if (u.bank == BANK_BAD) return res;
      hi   = u.key[63:32];
      half = ENTRIES / 2;
      if (u.bank == BANK_SHARED) idx = hi & (ENTRIES - 1);
      else if (u.bank == BANK_BLACK) idx = hi & (half - 1);
      else idx = half | (hi & (half - 1));
      date = (u.bank == BANK_WHITE) ? int'(age_white) : int'(age_black);
      if (u.cmd == CMD_FULL && u.pv) date++;
      dk = deep_key_mem[idx];
      d  = deep_rec_mem[idx];
      nk = new_key_mem[idx];
      n  = new_rec_mem[idx];
      if (record_matches(dk, d, u)) begin
         d = tighten_bounds(d, u);
         d.date = date[7:0];
         d.move = u.move;
         deep_rec_mem[idx] = d;
         deep_key_mem[idx] = u.key;
         res.action = ACT_DEEP_REFINED;
      end else if (record_matches(nk, n, u)) begin
         n = tighten_bounds(n, u);
         n.date = date[7:0];
         n.move = u.move;
         new_rec_mem[idx] = n;
         new_key_mem[idx] = u.key;
         res.action = ACT_NEW_REFINED;
      end else begin
         deep_first = dk == u.key || int'(d.date) < date ||
                      (int'(d.date) == date &&
                       (d.depth < u.depth || (d.depth == u.depth && d.sel < u.sel)));
         if (deep_first) begin
            demote = dk != u.key &&
                     (nk == u.key || n.date < d.date ||
                      (n.date == d.date &&
                       (n.depth < d.depth || (n.depth == d.depth && n.sel <= d.sel))));
            if (demote) begin
               new_key_mem[idx] = dk;
               new_rec_mem[idx] = d;
               res.demoted = 1'b1;
            end
            d.depth = u.depth;
            d.date  = date[7:0];
            d.sel   = u.sel;
            d       = with_fresh_bounds(d, u);
            d.move  = u.move;
            deep_rec_mem[idx] = d;
            deep_key_mem[idx] = u.key;
            res.action = ACT_DEEP_REPLACED;
         end else begin
            n.depth = u.depth;
            n.date  = date[7:0];
            n.sel   = u.sel;
            n       = with_fresh_bounds(n, u);
            n.move  = u.move;
            new_rec_mem[idx] = n;
            new_key_mem[idx] = u.key;
            res.action = ACT_NEW_REPLACED;
         end
      end
      return res;
   endfunction

   function automatic store_update_type build_update(
      logic cmd, logic [63:0] key, logic [1:0] bank, logic pv, logic [7:0] sel,
      logic [7:0] depth, int alpha, int beta, int score, logic [7:0] move
   );
      store_update_type u;
      u.cmd   = cmd;
      u.key   = key;
      u.bank  = bank;
      u.pv    = pv;
      u.sel   = sel;
      u.depth = depth;
      u.alpha = 16'(alpha);
      u.beta  = 16'(beta);
      u.score = 16'(score);
      u.move  = move;
      return u;
   endfunction

   task automatic send_update(store_update_type u);
      update_outcome_type outcome;
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.cmd               <= u.cmd;
      req_bus.key               <= u.key;
      req_bus.bank              <= u.bank;
      req_bus.pv_bonus          <= u.pv;
      req_bus.selectivity_level <= u.sel;
      req_bus.search_depth      <= u.depth;
      req_bus.window_low        <= u.alpha;
      req_bus.window_high       <= u.beta;
      req_bus.score             <= u.score;
      req_bus.best_move         <= u.move;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      outcome = predict_update(u);
      pending_outcomes.push_back(outcome);
      action_tally[outcome.action]++;
      if (outcome.demoted) demotions++;
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic write_age(tts_reg_type which, logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= {24'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (which == REG_AGE_BLACK) age_black = value;
      else age_white = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_directed_corners();
      write_age(REG_AGE_BLACK, 8'd255);
      write_age(REG_AGE_WHITE, 8'd0);
      // A zero key with zero depth and selectivity matches the cleared record.
      send_update(build_update(CMD_FULL, 64'h0, BANK_SHARED, 1'b0, 8'd0, 8'd0,
                               -32768, 32767, 0, 8'h00));
      send_update(build_update(CMD_NULL, 64'h0, BANK_SHARED, 1'b1, 8'd0, 8'd0,
                               32767, -32768, -32768, 8'hFF));
      // The bonus date wraps past 255 and still wins over the stored date.
      send_update(build_update(CMD_FULL, 64'h0000_0000_FFFF_FFFF, BANK_SHARED, 1'b1,
                               8'hFF, 8'hFF, -100, 100, 50, 8'h5A));
      send_update(build_update(CMD_FULL, 64'h0000_0000_FFFF_FFFF, BANK_SHARED, 1'b1,
                               8'hFF, 8'hFF, -200, 40, 60, 8'hA5));
      send_update(build_update(CMD_FULL, 64'h0000_0000_1234_5678, BANK_SHARED, 1'b0,
                               8'd0, 8'd0, 0, 0, 0, 8'h01));
      send_update(build_update(CMD_NULL, 64'h0000_0000_1234_5678, BANK_SHARED, 1'b0,
                               8'd0, 8'd0, 0, 0, 0, 8'h02));
      send_update(build_update(CMD_FULL, '1, BANK_BAD, 1'b1, 8'hFF, 8'hFF,
                               32767, -32768, 32767, 8'hFF));
      send_update(build_update(CMD_NULL, '1, BANK_BLACK, 1'b1, 8'hFF, 8'hFF,
                               0, 32767, 32767, 8'h80));
      send_update(build_update(CMD_FULL, '1, BANK_WHITE, 1'b0, 8'hFF, 8'hFF,
                               32767, -32768, -32768, 8'h7F));
      send_update(build_update(CMD_FULL, 64'hFFFF_FFFF_0000_0000, BANK_WHITE, 1'b0,
                               8'd3, 8'd10, -50, 50, 0, 8'h11));
      send_update(build_update(CMD_NULL, 64'hFFFF_FFFF_0000_0000, BANK_WHITE, 1'b1,
                               8'd3, 8'd10, 6000, -1, 7000, 8'h22));
      send_update(build_update(CMD_NULL, 64'hFFFF_FFFF_0000_0000, BANK_WHITE, 1'b0,
                               8'd3, 8'd10, 0, 0, -7000, 8'h33));
      send_update(build_update(CMD_FULL, 64'h0000_0FFF_0000_0000, BANK_SHARED, 1'b0,
                               8'd1, 8'd1, 6399, 6401, 6400, 8'h44));
      send_update(build_update(CMD_FULL, 64'h8000_0000_0000_0001, BANK_BLACK, 1'b0,
                               8'd2, 8'd2, -6401, -6399, -6400, 8'h55));
      send_update(build_update(CMD_FULL, 64'hAAAA_AAAA_5555_5555, BANK_SHARED, 1'b1,
                               8'hAA, 8'h55, -21846, 21845, 1, 8'hAA));
      send_update(build_update(CMD_NULL, 64'h5555_5555_AAAA_AAAA, BANK_SHARED, 1'b0,
                               8'h55, 8'hAA, 21845, -21846, -1, 8'h55));
   endtask

   task automatic test_random_updates(int count, logic [7:0] black, logic [7:0] white,
                                      int idle_pct, int stall_pct);
      store_update_type u;
      int               k, s;
      wait_for_drain();
      write_age(REG_AGE_BLACK, black);
      write_age(REG_AGE_WHITE, white);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         if ($urandom_range(9) < 7) begin
            // Most requests revisit a few colliding entries so bounds get refined.
            k       = int'($urandom_range(KEY_POOL_SIZE - 1));
            u.cmd   = 1'($urandom_range(1));
            u.key   = key_pool[k];
            u.bank  = ($urandom_range(4) == 0) ? 2'($urandom_range(2)) : pool_bank[k];
            u.pv    = ($urandom_range(3) == 0);
            u.depth = ($urandom_range(3) != 0) ? pool_depth[k] : 8'($urandom_range(3));
            u.sel   = ($urandom_range(3) != 0) ? pool_sel[k] : 8'($urandom_range(2));
            if ($urandom_range(9) == 0) begin
               u.score = 16'($urandom);
               u.alpha = 16'($urandom);
               u.beta  = 16'($urandom);
            end else begin
               s       = int'($urandom_range(800)) - 400;
               u.score = 16'(s);
               u.alpha = 16'(s + 20 - int'($urandom_range(100)));
               u.beta  = 16'(s - 20 + int'($urandom_range(100)));
            end
            u.move = 8'($urandom);
         end else begin
            u.cmd   = 1'($urandom_range(1));
            u.key   = {$urandom, $urandom};
            u.bank  = 2'($urandom_range(3));
            u.pv    = 1'($urandom_range(1));
            u.sel   = 8'($urandom);
            u.depth = 8'($urandom);
            u.alpha = 16'($urandom);
            u.beta  = 16'($urandom);
            u.score = 16'($urandom);
            u.move  = 8'($urandom);
         end
         send_update(u);
      end
   endtask

   initial begin
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid             = 1'b0;
      req_bus.cmd               = CMD_FULL;
      req_bus.key               = '0;
      req_bus.bank              = BANK_SHARED;
      req_bus.pv_bonus          = 1'b0;
      req_bus.selectivity_level = '0;
      req_bus.search_depth      = '0;
      req_bus.window_low        = '0;
      req_bus.window_high       = '0;
      req_bus.score             = '0;
      req_bus.best_move         = '0;
      age_black = '0;
      age_white = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         deep_key_mem[i] = '0;
         deep_rec_mem[i] = '0;
         new_key_mem[i]  = '0;
         new_rec_mem[i]  = '0;
      end
      for (int i = 0; i < KEY_POOL_SIZE; i++) begin
         key_pool[i]        = {$urandom, $urandom};
         key_pool[i][43:32] = shared_spots[$urandom_range(2)];
         pool_bank[i]       = 2'($urandom_range(2));
         pool_depth[i]      = 8'($urandom_range(3));
         pool_sel[i]        = 8'($urandom_range(2));
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_updates(545, 8'd0, 8'd255, 16, 55);
      test_random_updates(545, 8'd255, 8'd128, 55, 16);
      test_random_updates(545, 8'd1, 8'd254, 0, 0);
      wait_for_drain();
      repeat (16) @(posedge clock);
      $display("Sent %0d requests: directed corners, then three age settings and idle mixes.",
               requests_sent);
      $display({"Refined %0d/%0d, replaced %0d/%0d (deepest/newest), ",
                "%0d ignored, %0d demoted; %0d mismatches."},
               action_tally[ACT_DEEP_REFINED], action_tally[ACT_NEW_REFINED],
               action_tally[ACT_DEEP_REPLACED], action_tally[ACT_NEW_REPLACED],
               action_tally[ACT_NO_CHANGE], demotions, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_CYCLES * 12);
      $display("Timed out with %0d responses outstanding.", pending_outcomes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
design/tts_pkg.sv
design/tts_req_if.sv
design/tts_rsp_if.sv
design/tts_ram.sv
design/tts_csr.sv
design/tts_ctrl.sv
design/tts_dpath.sv
design/two_tier_transposition_store.sv
tb/two_tier_transposition_store_tb.sv
